### design/hgpl_pkg.sv
// Types, widths and constants shared by the hex grid point locator.
package hgpl_pkg;

  localparam int ADDR_W = 5;
  localparam int DW     = 25;
  localparam int PW     = 50;
  localparam int EW     = 22;
  localparam int AW     = 47;
  localparam int UW     = 22;
  localparam int VW     = 21;
  localparam int HUW    = 42;
  localparam int RVW    = 41;
  localparam int SW     = 43;
  localparam int HRW    = 41;
  localparam int R3W    = 22;
  localparam int NCAND  = 7;

  localparam logic [2:0] REG_HEX_SIZE      = 3'd0;
  localparam logic [2:0] REG_HEX_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X      = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd3;
  localparam logic [2:0] REG_INV_COL_PITCH = 3'd4;
  localparam logic [2:0] REG_INV_ROW_PITCH = 3'd5;
  localparam logic [2:0] REG_GRID_COLS     = 3'd6;
  localparam logic [2:0] REG_GRID_ROWS     = 3'd7;

  localparam logic signed [1:0] CAND_DC [0:NCAND-1] =
    '{2'sd0, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd0, -2'sd1};
  localparam logic signed [1:0] CAND_DR [0:NCAND-1] =
    '{2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } point_t;

  typedef struct packed {
    logic       hit;
    logic [9:0] cell_col;
    logic [9:0] cell_row;
  } cell_t;

  typedef struct packed {
    logic [19:0]        hex_size;
    logic [19:0]        hex_height;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [23:0]        inv_col_pitch;
    logic [23:0]        inv_row_pitch;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [EW-1:0] ec;
    logic signed [EW-1:0] er;
  } est_t;

  typedef struct packed {
    logic                       valid;
    logic [NCAND-1:0]           ok;
    logic [NCAND-1:0][UW-1:0]   u;
    logic [NCAND-1:0][VW-1:0]   v;
    logic signed [EW-1:0]       ec;
    logic signed [EW-1:0]       er;
  } cand_t;

endpackage

### design/hgpl_estimate.sv
// Offset from the origin, reciprocal multiplies and the truncated column and row estimate.
module hgpl_estimate (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            point_valid,
  input  hgpl_pkg::point_t point,
  input  hgpl_pkg::cfg_t   cfg,
  output hgpl_pkg::est_t   est
);
  import hgpl_pkg::*;

  logic                 v1, v2;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [PW-1:0] pc2, pr2;

  logic signed [PW-1:0] pc_b, qp, qn, q, q_b;
  logic signed [EW-1:0] ec_n, er_n;

  always_comb begin
    pc_b = pc2 + $signed({22'd0, {28{pc2[PW-1]}}});
    ec_n = pc_b[PW-1:28];
    qp   = pr2 - 50'sd134217728;
    qn   = pr2 + 50'sd134217728;
    if (ec_n[0]) begin
      q = ec_n[EW-1] ? qn : qp;
    end else begin
      q = pr2;
    end
    q_b  = q + $signed({22'd0, {28{q[PW-1]}}});
    er_n = q_b[PW-1:28];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1    <= DW'(point.point_x) - DW'(cfg.origin_x);
      dy1    <= DW'(point.point_y) - DW'(cfg.origin_y);
      pc2    <= dx1 * $signed({1'b0, cfg.inv_col_pitch});
      pr2    <= dy1 * $signed({1'b0, cfg.inv_row_pitch});
      dx2    <= dx1;
      dy2    <= dy1;
      est.dx <= dx2;
      est.dy <= dy2;
      est.ec <= ec_n;
      est.er <= er_n;
    end
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      est.valid <= 1'b0;
    end else if (en) begin
      v1        <= point_valid;
      v2        <= v1;
      est.valid <= v2;
    end
  end

endmodule

### design/hgpl_candidates.sv
// Hexagon-local coordinates and range flags for the seven candidate cells.
module hgpl_candidates #(
  parameter int CW = 11,
  parameter int RW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  hgpl_pkg::est_t    est,
  input  logic [19:0]       hex_height,
  input  logic [21:0]       r3,
  input  logic [CW-1:0]     ncols,
  input  logic [RW-1:0]     nrows,
  output hgpl_pkg::cand_t   cand
);
  import hgpl_pkg::*;

  localparam int CAW = EW + 1;

  logic                 v4;
  logic signed [AW-1:0] a4, b4;
  logic signed [EW-1:0] ec4, er4;
  logic signed [AW-1:0] r3x;
  logic signed [44:0]   rc_n;
  logic signed [42:0]   hr_n;

  logic [NCAND-1:0]         ok_n;
  logic [NCAND-1:0][UW-1:0] u_n;
  logic [NCAND-1:0][VW-1:0] v_n;

  assign r3x  = AW'($signed({1'b0, r3}));
  assign rc_n = $signed({1'b0, r3}) * est.ec;
  assign hr_n = $signed({1'b0, hex_height}) * est.er;

  genvar j;
  for (j = 0; j < NCAND; j++) begin : g_cand
    logic signed [CAW-1:0] c, w;
    logic signed [3:0]     m;
    logic signed [24:0]    hm;
    logic signed [AW-1:0]  uf, vf, ua, va;

    assign c  = CAW'(ec4) + CAW'(CAND_DC[j]);
    assign w  = CAW'(er4) + CAW'(CAND_DR[j]);
    assign m  = 4'(CAND_DR[j]) * 4'sd2 + $signed({3'b000, c[0]});
    assign hm = m * $signed({1'b0, hex_height});
    assign uf = (CAND_DC[j] > 0) ? a4 - r3x : ((CAND_DC[j] < 0) ? a4 + r3x : a4);
    assign vf = b4 - AW'(hm);
    assign ua = uf[AW-1] ? -uf : uf;
    assign va = vf[AW-1] ? -vf : vf;

    assign ok_n[j] = !c[CAW-1] && (c[CAW-2:0] < EW'(ncols))
                  && !w[CAW-1] && (w[CAW-2:0] < EW'(nrows));
    assign u_n[j]  = (|ua[AW-1:UW-1]) ? UW'(1 << (UW - 1)) : ua[UW-1:0];
    assign v_n[j]  = (|va[AW-1:VW-1]) ? VW'(1 << (VW - 1)) : va[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4      <= (AW'(est.dx) <<< 1) - AW'(rc_n);
      b4      <= (AW'(est.dy) <<< 1) - (AW'(hr_n) <<< 1);
      ec4     <= est.ec;
      er4     <= est.er;
      cand.ok <= ok_n;
      cand.u  <= u_n;
      cand.v  <= v_n;
      cand.ec <= ec4;
      cand.er <= er4;
    end
    if (rst) begin
      v4         <= 1'b0;
      cand.valid <= 1'b0;
    end else if (en) begin
      v4         <= est.valid;
      cand.valid <= v4;
    end
  end

endmodule

### design/hgpl_contain.sv
// Hexagon containment tests for the candidates and first-hit selection into the result register.
module hgpl_contain (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hgpl_pkg::cand_t     cand,
  input  logic [19:0]         hex_size,
  input  logic [19:0]         hex_height,
  input  logic [40:0]         hr2,
  output logic                cell_valid,
  output hgpl_pkg::cell_t     loc
);
  import hgpl_pkg::*;

  logic                      v6, v7;
  logic [NCAND-1:0][HUW-1:0] hu6, hu_n;
  logic [NCAND-1:0][RVW-1:0] rv6, rv_n;
  logic [NCAND-1:0]          ok6, vlt6, vlt_n, in7, in_n;
  logic signed [EW-1:0]      ec6, er6, ec7, er7;
  cell_t                     cell_n;

  genvar j;
  for (j = 0; j < NCAND; j++) begin : g_test
    assign hu_n[j]  = HUW'(hex_height) * HUW'(cand.u[j]);
    assign rv_n[j]  = RVW'(hex_size) * RVW'(cand.v[j]);
    assign vlt_n[j] = cand.v[j] < VW'(hex_height);
    assign in_n[j]  = ok6[j] && vlt6[j] && ((SW'(hu6[j]) + SW'(rv6[j])) < SW'(hr2));
  end

  always_comb begin
    logic signed [EW-1:0] cc, rr;
    cell_n = '0;
    cc     = '0;
    rr     = '0;
    for (int k = NCAND - 1; k >= 0; k--) begin
      if (in7[k]) begin
        cc              = ec7 + EW'(CAND_DC[k]);
        rr              = er7 + EW'(CAND_DR[k]);
        cell_n.hit      = 1'b1;
        cell_n.cell_col = cc[9:0];
        cell_n.cell_row = rr[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hu6  <= hu_n;
      rv6  <= rv_n;
      vlt6 <= vlt_n;
      ok6  <= cand.ok;
      ec6  <= cand.ec;
      er6  <= cand.er;
      in7  <= in_n;
      ec7  <= ec6;
      er7  <= er6;
      loc  <= cell_n;
    end
    if (rst) begin
      v6         <= 1'b0;
      v7         <= 1'b0;
      cell_valid <= 1'b0;
    end else if (en) begin
      v6         <= cand.valid;
      v7         <= v6;
      cell_valid <= v7;
    end
  end

endmodule

### design/hex_grid_point_locate.sv
// Top level of the hex grid point locator: register port, derived constants and pipeline.
//
//   Channel   Direction  Handshake                Payload
//   point     in         point_valid/point_stall  point_t (point_x, point_y)
//   cell      out        cell_valid/cell_stall    cell_t on loc (hit, cell_col, cell_row)
//   config    in         APB psel/penable/pready  8 registers at 4*index
//
// One request enters per cycle while point_stall is low. The pipeline has eight
// register stages: offset, multiply, truncate, local offset, candidate geometry,
// containment products, compare and select.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline and raises point_stall.
module hex_grid_point_locate #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  hgpl_pkg::point_t              point,
  output logic                          cell_valid,
  input  logic                          cell_stall,
  output hgpl_pkg::cell_t               loc,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hgpl_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hgpl_pkg::*;

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  cfg_t            cfg;
  logic [10:0]     grid_cols, grid_rows;
  logic [CW-1:0]   ncols;
  logic [RW-1:0]   nrows;
  logic [R3W-1:0]  r3;
  logic [HRW-1:0]  hr2;
  logic            en;
  est_t            est;
  cand_t           cand;

  assign pready      = 1'b1;
  assign en          = !(cell_valid && cell_stall);
  assign point_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hex_size      <= 20'd4096;
      cfg.hex_height    <= 20'd7094;
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.inv_col_pitch <= 24'd43691;
      cfg.inv_row_pitch <= 24'd37837;
      grid_cols         <= 11'd16;
      grid_rows         <= 11'd16;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_HEX_SIZE:      cfg.hex_size      <= pwdata[19:0];
        REG_HEX_HEIGHT:    cfg.hex_height    <= pwdata[19:0];
        REG_ORIGIN_X:      cfg.origin_x      <= $signed(pwdata[23:0]);
        REG_ORIGIN_Y:      cfg.origin_y      <= $signed(pwdata[23:0]);
        REG_INV_COL_PITCH: cfg.inv_col_pitch <= pwdata[23:0];
        REG_INV_ROW_PITCH: cfg.inv_row_pitch <= pwdata[23:0];
        REG_GRID_COLS:     grid_cols         <= pwdata[10:0];
        REG_GRID_ROWS:     grid_rows         <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_HEX_SIZE:      prdata = 32'(cfg.hex_size);
      REG_HEX_HEIGHT:    prdata = 32'(cfg.hex_height);
      REG_ORIGIN_X:      prdata = {8'd0, cfg.origin_x};
      REG_ORIGIN_Y:      prdata = {8'd0, cfg.origin_y};
      REG_INV_COL_PITCH: prdata = 32'(cfg.inv_col_pitch);
      REG_INV_ROW_PITCH: prdata = 32'(cfg.inv_row_pitch);
      REG_GRID_COLS:     prdata = 32'(grid_cols);
      REG_GRID_ROWS:     prdata = 32'(grid_rows);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    ncols <= (32'(grid_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols);
    nrows <= (32'(grid_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(grid_rows);
    r3    <= R3W'(cfg.hex_size) * R3W'(3);
    hr2   <= {40'(cfg.hex_height) * 40'(cfg.hex_size), 1'b0};
  end

  hgpl_estimate u_estimate (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .point_valid (point_valid),
    .point       (point),
    .cfg         (cfg),
    .est         (est)
  );

  hgpl_candidates #(
    .CW (CW),
    .RW (RW)
  ) u_candidates (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .est        (est),
    .hex_height (cfg.hex_height),
    .r3         (r3),
    .ncols      (ncols),
    .nrows      (nrows),
    .cand       (cand)
  );

  hgpl_contain u_contain (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cand       (cand),
    .hex_size   (cfg.hex_size),
    .hex_height (cfg.hex_height),
    .hr2        (hr2),
    .cell_valid (cell_valid),
    .loc        (loc)
  );

endmodule

### design/hgpl_checker.sv
// Port-level checks for the hex grid point locator and their binding to the top level.
module hgpl_checker (
  input logic             clk,
  input logic             rst,
  input logic             point_stall,
  input logic             cell_valid,
  input logic             cell_stall,
  input hgpl_pkg::cell_t  loc
);
  import hgpl_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !cell_valid)
    else $error("Result valid after reset.");

  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    point_stall == (cell_valid && cell_stall))
    else $error("Request stall does not follow a held result.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && !loc.hit) |-> (loc.cell_col == '0 && loc.cell_row == '0))
    else $error("Miss result carries a nonzero cell.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && cell_stall) |=> (cell_valid && $stable(loc)))
    else $error("Stalled result changed.");

endmodule

bind hex_grid_point_locate hgpl_checker u_hgpl_checker (.*);
